/* src/psd_pkg.sv */
// Shared types, constants and the square-root step for the point-to-segment distance block.
// Depends on nothing; every other file of the block but psd_if.sv uses it.
`default_nettype none
package psd_pkg;

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned DIST_W     = 31;
    localparam int unsigned RAD_W      = 64;
    localparam int unsigned REM_W      = 35;
    localparam int unsigned ROOT_W     = 32;
    localparam int unsigned SQRT_STEPS = 32;
    localparam int unsigned STEP_CNT_W = $clog2(SQRT_STEPS);
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef enum logic [2:0] {
        REG_ORIGIN_X   = 3'd0,
        REG_ORIGIN_Y   = 3'd1,
        REG_ORIGIN_Z   = 3'd2,
        REG_DIR_X      = 3'd3,
        REG_DIR_Y      = 3'd4,
        REG_DIR_Z      = 3'd5,
        REG_MAX_LENGTH = 3'd6
    } reg_index_t;

    typedef enum logic [2:0] {
        DIR_IDLE,
        DIR_LOAD,
        DIR_NORM,
        DIR_SQUARE,
        DIR_ROOT,
        DIR_DIV_INIT,
        DIR_DIV
    } dir_state_t;

    // Working set of the digit-by-digit square root: radicand bits still to
    // be consumed (two per step, from the top), partial remainder and root.
    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic              sat;
    } sqrt_cell_t;

    function automatic sqrt_cell_t sqrt_step(input sqrt_cell_t s);
        logic [REM_W-1:0] pre;
        logic [REM_W-1:0] trial;
        sqrt_cell_t       r;
        r     = s;
        pre   = {s.rem[REM_W-3:0], s.rad[RAD_W-1:RAD_W-2]};
        trial = {1'b0, s.root, 2'b01};
        r.rad = {s.rad[RAD_W-3:0], 2'b00};
        if (pre >= trial)
        begin
            r.rem  = pre - trial;
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = pre;
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* src/psd_if.sv */
// Valid/ready channels of the point-to-segment distance block: query points in, distances out.
// Depends on nothing.
`default_nettype none
interface psd_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z, input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface psd_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] dist_res;
    logic        saturated;

    modport source (output valid, output dist_res, output saturated, input ready);
    modport sink   (input valid, input dist_res, input saturated, output ready);
endinterface
`default_nettype wire

/* src/point_segment_distance.sv */
// Distance from a 3-D point to a clamped ray segment, signed fixed point with FRAC_BITS fractions.
// Pipeline of 7 arithmetic stages, 32 square-root cells and an output register; one item a cycle
// while results are taken. A direction write starts the unit-vector sequencer; points are held
// off until it finishes.
// Reset is asynchronous, active low: registers take their reset values, unit direction (1,0,0).
`default_nettype none
module point_segment_distance #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    psd_in_if.sink           query,
    psd_out_if.source        result,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    // Derived widths. The unit vector has magnitude at most 1.0, so FRAC_BITS+1 bits
    // of magnitude; the dot product grows by the offset width plus two for the sum.
    localparam int UW = FRAC_BITS + 2;
    localparam int QW = FRAC_BITS + 1;
    localparam int OW = 33;
    localparam int PW = OW + UW;
    localparam int DW = PW + 2;
    localparam int MW = 31 + QW;
    localparam int EW = 34;
    localparam int NSTG = 7;

    // Configuration registers.
    logic signed [31:0] origin_reg [3];
    logic signed [31:0] dir_reg [3];
    logic [30:0]        max_len_reg;
    logic               dir_start;

    always_comb
    begin
        unique case (psd_pkg::reg_index_t'(cfg_index)) inside
            psd_pkg::REG_DIR_X, psd_pkg::REG_DIR_Y, psd_pkg::REG_DIR_Z:
                dir_start = cfg_wr_en;
            default:
                dir_start = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
            dir_reg[0]    <= 32'sd1 <<< 16;
            dir_reg[1]    <= '0;
            dir_reg[2]    <= '0;
            max_len_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (psd_pkg::reg_index_t'(cfg_index))
                psd_pkg::REG_ORIGIN_X:   origin_reg[0] <= cfg_data;
                psd_pkg::REG_ORIGIN_Y:   origin_reg[1] <= cfg_data;
                psd_pkg::REG_ORIGIN_Z:   origin_reg[2] <= cfg_data;
                psd_pkg::REG_DIR_X:      dir_reg[0]    <= cfg_data;
                psd_pkg::REG_DIR_Y:      dir_reg[1]    <= cfg_data;
                psd_pkg::REG_DIR_Z:      dir_reg[2]    <= cfg_data;
                psd_pkg::REG_MAX_LENGTH: max_len_reg   <= cfg_data[30:0];
                default:
                begin
                end
            endcase
        end
    end

    // Unit direction, recomputed after each direction write.
    logic                 dir_busy;
    logic signed [UW-1:0] u [3];
    logic [QW-1:0]        umag [3];

    psd_dir_unit #(.FRAC_BITS(FRAC_BITS)) u_dir (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dir_start),
        .dir   (dir_reg),
        .busy  (dir_busy),
        .u     (u)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            umag[i] = u[i][UW-1] ? QW'(-u[i]) : QW'(u[i]);
    end

    // Arithmetic stages. Each stage holds when its successor is full and stalled.
    logic v_reg [NSTG];
    logic adv [NSTG];
    logic cell_ready [psd_pkg::SQRT_STEPS+1];
    logic cell_valid [psd_pkg::SQRT_STEPS+1];
    psd_pkg::sqrt_cell_t cell_data [psd_pkg::SQRT_STEPS+1];

    always_comb
    begin
        for (int k = 0; k < NSTG - 1; k++)
            adv[k] = !v_reg[k] || adv[k+1];
        adv[NSTG-1] = !v_reg[NSTG-1] || cell_ready[0];
    end

    assign query.ready = adv[0] && !dir_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NSTG; k++)
                v_reg[k] <= 1'b0;
        end
        else
        begin
            if (adv[0])
                v_reg[0] <= query.valid && query.ready;
            for (int k = 1; k < NSTG; k++)
            begin
                if (adv[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    logic signed [31:0]   pt [3];
    logic signed [OW-1:0] op1_reg [3];
    logic signed [OW-1:0] op2_reg [3];
    logic signed [OW-1:0] op3_reg [3];
    logic signed [OW-1:0] op4_reg [3];
    logic signed [PW-1:0] prod2_reg [3];
    logic [30:0]          t3_reg;
    logic [MW-1:0]        cm4_reg [3];
    logic [30:0]          em5_reg [3];
    logic                 sat5_reg;
    logic [61:0]          sq6_reg [3];
    logic                 sat6_reg;
    psd_pkg::sqrt_cell_t  s7_reg;

    logic signed [DW-1:0] dot3;
    logic signed [DW-1:0] dot3_shift;
    logic [30:0]          t3;
    logic [31:0]          cq5 [3];
    logic signed [EW-1:0] c5 [3];
    logic signed [EW-1:0] e5 [3];
    logic [EW-1:0]        em5 [3];
    logic                 sat5;

    assign pt[0] = query.point_x;
    assign pt[1] = query.point_y;
    assign pt[2] = query.point_z;

    // Dot product of the offset with the unit direction, then the clamp to the segment.
    always_comb
    begin
        dot3 = DW'(prod2_reg[0]) + DW'(prod2_reg[1]) + DW'(prod2_reg[2]);
        dot3_shift = dot3 >>> FRAC_BITS;
        if (dot3 <= 0)
            t3 = '0;
        else if (dot3_shift > $signed(DW'(max_len_reg)))
            t3 = max_len_reg;
        else
            t3 = dot3_shift[30:0];
    end

    // Closest point per axis, truncated toward zero, and the error vector.
    // An error of 2^31 or more cannot fit the result and forces saturation.
    always_comb
    begin
        sat5 = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            cq5[i] = cm4_reg[i][MW-1:FRAC_BITS];
            c5[i]  = u[i][UW-1] ? -$signed(EW'(cq5[i])) : $signed(EW'(cq5[i]));
            e5[i]  = EW'(op4_reg[i]) - c5[i];
            em5[i] = e5[i][EW-1] ? EW'(-e5[i]) : EW'(e5[i]);
            if (|em5[i][EW-1:31])
                sat5 = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int i = 0; i < 3; i++)
                op1_reg[i] <= OW'(pt[i]) - OW'(origin_reg[i]);
        end
        if (adv[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod2_reg[i] <= PW'(op1_reg[i]) * PW'(u[i]);
                op2_reg[i]   <= op1_reg[i];
            end
        end
        if (adv[2])
        begin
            t3_reg  <= t3;
            op3_reg <= op2_reg;
        end
        if (adv[3])
        begin
            for (int i = 0; i < 3; i++)
                cm4_reg[i] <= MW'(t3_reg) * MW'(umag[i]);
            op4_reg <= op3_reg;
        end
        if (adv[4])
        begin
            for (int i = 0; i < 3; i++)
                em5_reg[i] <= em5[i][30:0];
            sat5_reg <= sat5;
        end
        if (adv[5])
        begin
            for (int i = 0; i < 3; i++)
                sq6_reg[i] <= {31'd0, em5_reg[i]} * {31'd0, em5_reg[i]};
            sat6_reg <= sat5_reg;
        end
        if (adv[6])
        begin
            s7_reg.rad  <= {2'b00, sq6_reg[0]} + {2'b00, sq6_reg[1]} + {2'b00, sq6_reg[2]};
            s7_reg.rem  <= '0;
            s7_reg.root <= '0;
            s7_reg.sat  <= sat6_reg;
        end
    end

    // Row of square-root cells: each one settles one bit of the root and passes the
    // item on to its neighbor, so a new sum enters the row in every cycle while the output is taken.
    assign cell_valid[0] = v_reg[NSTG-1];
    assign cell_data[0]  = s7_reg;

    for (genvar g = 0; g < psd_pkg::SQRT_STEPS; g++)
    begin : g_cell
        psd_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (cell_valid[g]),
            .up_data  (cell_data[g]),
            .up_ready (cell_ready[g]),
            .dn_valid (cell_valid[g+1]),
            .dn_data  (cell_data[g+1]),
            .dn_ready (cell_ready[g+1])
        );
    end

    // Output register. A root with bit 31 set is beyond the result range.
    logic        out_v_reg;
    logic [30:0] out_dist_reg;
    logic        out_sat_reg;
    logic        out_adv;
    logic        sat_fin;

    assign out_adv = !out_v_reg || result.ready;
    assign cell_ready[psd_pkg::SQRT_STEPS] = out_adv;
    assign sat_fin = cell_data[psd_pkg::SQRT_STEPS].sat
                  || cell_data[psd_pkg::SQRT_STEPS].root[31];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (out_adv)
            out_v_reg <= cell_valid[psd_pkg::SQRT_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && cell_valid[psd_pkg::SQRT_STEPS])
        begin
            out_dist_reg <= sat_fin ? psd_pkg::DIST_MAX
                                    : cell_data[psd_pkg::SQRT_STEPS].root[30:0];
            out_sat_reg  <= sat_fin;
        end
    end

    assign result.valid     = out_v_reg;
    assign result.dist_res  = out_dist_reg;
    assign result.saturated = out_sat_reg;

    // While the unit direction is being recomputed no point may enter.
    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        dir_busy |-> !query.ready)
        else $error("point accepted while the direction unit is busy");

    // A saturated item always carries the largest distance.
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.saturated) |-> (result.dist_res == psd_pkg::DIST_MAX))
        else $error("saturated item without the maximum distance");

    // A finished unit vector never exceeds 1.0 on any axis.
    a_unit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !dir_busy |-> ((umag[0] <= (QW'(1) << FRAC_BITS)) && (umag[1] <= (QW'(1) << FRAC_BITS))
                       && (umag[2] <= (QW'(1) << FRAC_BITS))))
        else $error("unit direction component above one");
endmodule
`default_nettype wire

/* src/psd_sqrt_cell.sv */
// One cell of the square-root row: one root bit per cell, with its own valid/ready stage.
// Depends on psd_pkg.
`default_nettype none
module psd_sqrt_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               up_valid,
    input  wire psd_pkg::sqrt_cell_t up_data,
    output logic                    up_ready,
    output logic                    dn_valid,
    output psd_pkg::sqrt_cell_t     dn_data,
    input  wire logic               dn_ready
);
    logic                valid_reg;
    psd_pkg::sqrt_cell_t data_reg;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= psd_pkg::sqrt_step(up_data);
    end
endmodule
`default_nettype wire

/* src/psd_dir_unit.sv */
// Sequencer that turns the configured direction into a unit vector with FRAC_BITS fraction bits.
// Depends on psd_pkg (state type, square-root step).
`default_nettype none
module psd_dir_unit #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic signed [31:0]        dir [3],
    output logic                           busy,
    output logic signed [FRAC_BITS+1:0]    u [3]
);
    localparam int UW = FRAC_BITS + 2;
    localparam int QW = FRAC_BITS + 1;
    localparam int CW = psd_pkg::STEP_CNT_W;

    psd_pkg::dir_state_t state_reg, state_next;
    logic [31:0]         dm_reg [3];
    logic [31:0]         dm_next [3];
    logic                neg_reg [3];
    logic                neg_next [3];
    logic signed [UW-1:0] u_reg [3];
    logic signed [UW-1:0] u_next [3];
    psd_pkg::sqrt_cell_t sq_reg, sq_next;
    logic [32:0]         rem_reg, rem_next;
    logic [QW-1:0]       q_reg, q_next;
    logic [1:0]          axis_reg, axis_next;
    logic [CW-1:0]       cnt_reg, cnt_next;

    assign busy = (state_reg != psd_pkg::DIR_IDLE);
    assign u    = u_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psd_pkg::DIR_IDLE;
            u_reg[0]  <= UW'(1) << FRAC_BITS;
            u_reg[1]  <= '0;
            u_reg[2]  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            u_reg     <= u_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dm_reg   <= dm_next;
        neg_reg  <= neg_next;
        sq_reg   <= sq_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        axis_reg <= axis_next;
        cnt_reg  <= cnt_next;
    end

    always_comb
    begin
        logic [32:0]   rem2;
        logic [QW-1:0] q_new;
        logic [63:0]   sq_prod;
        state_next = state_reg;
        dm_next    = dm_reg;
        neg_next   = neg_reg;
        u_next     = u_reg;
        sq_next    = sq_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        axis_next  = axis_reg;
        cnt_next   = cnt_reg;
        rem2       = {rem_reg[31:0], 1'b0};
        q_new      = q_reg;
        sq_prod    = {32'd0, dm_reg[axis_reg]} * {32'd0, dm_reg[axis_reg]};
        unique case (state_reg)
            psd_pkg::DIR_IDLE:
            begin
            end
            psd_pkg::DIR_LOAD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    neg_next[i] = dir[i][31];
                    dm_next[i]  = dir[i][31] ? (~dir[i] + 32'd1) : dir[i];
                end
                if (dir[0] == 0 && dir[1] == 0 && dir[2] == 0)
                begin
                    for (int i = 0; i < 3; i++)
                        u_next[i] = '0;
                    state_next = psd_pkg::DIR_IDLE;
                end
                else
                    state_next = psd_pkg::DIR_NORM;
            end
            psd_pkg::DIR_NORM:
            begin
                // Shift all three until the largest magnitude reaches bit 30.
                if (!(|{dm_reg[0][31:30], dm_reg[1][31:30], dm_reg[2][31:30]}))
                begin
                    for (int i = 0; i < 3; i++)
                        dm_next[i] = {dm_reg[i][30:0], 1'b0};
                end
                else
                begin
                    state_next  = psd_pkg::DIR_SQUARE;
                    axis_next   = 2'd0;
                    sq_next.rad = '0;
                end
            end
            psd_pkg::DIR_SQUARE:
            begin
                sq_next.rad = sq_reg.rad + sq_prod;
                if (axis_reg == 2'd2)
                begin
                    state_next   = psd_pkg::DIR_ROOT;
                    sq_next.rem  = '0;
                    sq_next.root = '0;
                    sq_next.sat  = 1'b0;
                    cnt_next     = '0;
                end
                else
                    axis_next = axis_reg + 2'd1;
            end
            psd_pkg::DIR_ROOT:
            begin
                sq_next  = psd_pkg::sqrt_step(sq_reg);
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(psd_pkg::SQRT_STEPS - 1))
                begin
                    state_next = psd_pkg::DIR_DIV_INIT;
                    axis_next  = 2'd0;
                end
            end
            psd_pkg::DIR_DIV_INIT:
            begin
                // The length is at least every magnitude, so the integer part is 0 or 1.
                if (dm_reg[axis_reg] >= sq_reg.root)
                begin
                    q_next   = QW'(1);
                    rem_next = {1'b0, dm_reg[axis_reg] - sq_reg.root};
                end
                else
                begin
                    q_next   = '0;
                    rem_next = {1'b0, dm_reg[axis_reg]};
                end
                cnt_next   = '0;
                state_next = psd_pkg::DIR_DIV;
            end
            psd_pkg::DIR_DIV:
            begin
                if (rem2 >= {1'b0, sq_reg.root})
                begin
                    rem_next = rem2 - {1'b0, sq_reg.root};
                    q_new    = {q_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem2;
                    q_new    = {q_reg[QW-2:0], 1'b0};
                end
                q_next   = q_new;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(FRAC_BITS - 1))
                begin
                    u_next[axis_reg] = neg_reg[axis_reg] ? -$signed({1'b0, q_new})
                                                         : $signed({1'b0, q_new});
                    if (axis_reg == 2'd2)
                        state_next = psd_pkg::DIR_IDLE;
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = psd_pkg::DIR_DIV_INIT;
                    end
                end
            end
            default:
                state_next = psd_pkg::DIR_IDLE;
        endcase
        if (start)
            state_next = psd_pkg::DIR_LOAD;
    end
endmodule
`default_nettype wire

/* tb/psd_tb_if.sv */
// Testbench-side note: the block's channel interfaces come from src/psd_if.sv.
// This file holds the timescale and psd_tb_pkg with the cycle limit; it depends on nothing.
`timescale 1ns / 100ps
package psd_tb_pkg;
    localparam int unsigned CYCLE_LIMIT = 2000000;
endpackage

/* tb/point_segment_distance_tb.sv */
// Testbench of point_segment_distance: drives query points and configuration writes,
// predicts each distance in the testbench and compares every result item in order.
// Depends on psd_pkg, psd_if (psd_in_if, psd_out_if) and psd_tb_pkg.
`timescale 1ns / 100ps
module point_segment_distance_tb;

    localparam int FRAC = 16;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    psd_in_if query ();
    psd_out_if result ();

    point_segment_distance #(.FRAC_BITS(FRAC)) DUT (
        .clk(clk), .rst_n(rst_n), .query(query.sink), .result(result.source),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        query.valid = 1'b0;
        query.point_x = '0;
        query.point_y = '0;
        query.point_z = '0;
        result.ready = 1'b0;
    end

    typedef struct packed {
        logic [30:0] dist_val;
        logic        sat;
    } dist_item_t;

    // Shadow copy of the segment registers.
    logic signed [63:0] seg_org [3];
    logic signed [63:0] seg_dir [3];
    logic [63:0]        seg_max;

    dist_item_t expected_dist_q [$];
    int  error_count = 0;
    longint cycle_count = 0;

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] abs64(input logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    // Distance from the point to the clamped segment, as the block computes it.
    function automatic dist_item_t predict_distance(input logic signed [31:0] px,
                                                    input logic signed [31:0] py,
                                                    input logic signed [31:0] pz);
        logic signed [63:0] off [3];
        logic signed [63:0] unit [3];
        logic [63:0] mag [3];
        logic [63:0] big, len, q, tpar, cm, em, acc;
        logic signed [63:0] dot, cpt;
        dist_item_t r;
        bit sat;
        off[0] = px - seg_org[0];
        off[1] = py - seg_org[1];
        off[2] = pz - seg_org[2];
        big = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = abs64(seg_dir[i]);
            if (mag[i] > big)
                big = mag[i];
            unit[i] = 0;
        end
        if (big != 0)
        begin
            while (big < (64'd1 << 30))
            begin
                big = big << 1;
                for (int i = 0; i < 3; i++)
                    mag[i] = mag[i] << 1;
            end
            len = int_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
            for (int i = 0; i < 3; i++)
            begin
                q = (mag[i] << FRAC) / len;
                unit[i] = seg_dir[i] < 0 ? -$signed(q) : $signed(q);
            end
        end
        dot = off[0] * unit[0] + off[1] * unit[1] + off[2] * unit[2];
        if (dot <= 0)
            tpar = 0;
        else
        begin
            tpar = dot >> FRAC;
            if (tpar > seg_max)
                tpar = seg_max;
        end
        sat = 1'b0;
        acc = 0;
        for (int i = 0; i < 3; i++)
        begin
            cm = (tpar * abs64(unit[i])) >> FRAC;
            cpt = unit[i] < 0 ? -$signed(cm) : $signed(cm);
            em = abs64(off[i] - cpt);
            if (em >= (64'd1 << 31))
                sat = 1'b1;
            else
                acc = acc + em * em;
        end
        len = sat ? 64'h7FFF_FFFF : int_sqrt(acc);
        if (len > 64'h7FFF_FFFF)
        begin
            len = 64'h7FFF_FFFF;
            sat = 1'b1;
        end
        r.dist_val = len[30:0];
        r.sat = sat;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    // The sender and receiver each draw a wait before every item; some stretches run flat out.
    bit no_idle = 1'b0;

    // Valid stays high between back-to-back items; it drops only before a wait.
    task automatic send_point(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] pz);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            query.valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        query.valid <= 1'b1;
        query.point_x <= px;
        query.point_y <= py;
        query.point_z <= pz;
        @(posedge clk);
        while (!query.ready)
            @(posedge clk);
        // The item is taken at this edge; predict it now.
        expected_dist_q.push_back(predict_distance(px, py, pz));
    endtask

    // Waits for every expected item, then lets the direction sequencer and pipeline settle.
    task automatic drain_block();
        query.valid <= 1'b0;
        while (expected_dist_q.size() != 0)
            @(posedge clk);
        repeat (200)
            @(posedge clk);
    endtask

    // The write enable stays high across consecutive writes; set_segment drops it.
    task automatic write_reg(input psd_pkg::reg_index_t idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            psd_pkg::REG_ORIGIN_X:   seg_org[0] = $signed(val);
            psd_pkg::REG_ORIGIN_Y:   seg_org[1] = $signed(val);
            psd_pkg::REG_ORIGIN_Z:   seg_org[2] = $signed(val);
            psd_pkg::REG_DIR_X:      seg_dir[0] = $signed(val);
            psd_pkg::REG_DIR_Y:      seg_dir[1] = $signed(val);
            psd_pkg::REG_DIR_Z:      seg_dir[2] = $signed(val);
            psd_pkg::REG_MAX_LENGTH: seg_max = {33'd0, val[30:0]};
            default: ;
        endcase
    endtask

    task automatic set_segment(input logic [31:0] ox, input logic [31:0] oy,
                               input logic [31:0] oz, input logic [31:0] dx,
                               input logic [31:0] dy, input logic [31:0] dz,
                               input logic [31:0] ml);
        drain_block();
        write_reg(psd_pkg::REG_ORIGIN_X, ox);
        write_reg(psd_pkg::REG_ORIGIN_Y, oy);
        write_reg(psd_pkg::REG_ORIGIN_Z, oz);
        write_reg(psd_pkg::REG_DIR_X, dx);
        write_reg(psd_pkg::REG_DIR_Y, dy);
        write_reg(psd_pkg::REG_DIR_Z, dz);
        write_reg(psd_pkg::REG_MAX_LENGTH, ml);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    // Reset values: unit x direction, zero length, so distance is |p|.
    task automatic test_reset_segment();
        send_point(32'd0, 32'd0, 32'd0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h0001_0000, 32'hFFFF_0000, 32'd5);
    endtask

    // Extremes of the registers, a zero direction and projections on both clamps.
    task automatic test_directed();
        set_segment(32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'h0001_0000, 32'd0,
                    32'h7FFF_FFFF);
        send_point(32'h0010_0000, 32'h0010_0000, 32'd0);
        send_point(32'hFFF0_0000, 32'hFFF0_0000, 32'h0003_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        set_segment(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0, 32'd0,
                    32'h0100_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'd0, 32'd0, 32'd0);
        set_segment(32'd0, 32'd0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1,
                    32'h0004_0000);
        send_point(32'h8000_0000, 32'h0008_0000, 32'd0);
        send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        set_segment(32'h0002_0000, 32'hFFFE_0000, 32'd7, 32'd1, 32'hFFFF_FFFF,
                    32'h0000_8000, 32'd0);
        send_point(32'h0003_0000, 32'hFFFD_0000, 32'd9);
        send_point(32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF);
    endtask

    // Random segments and points; a mix of full-range and moderate values.
    task automatic test_random();
        for (int ph = 0; ph < 29; ph++)
        begin
            set_segment(rand_coord(), rand_coord(), rand_coord(),
                        ($urandom_range(0, 7) == 0) ? 32'd0 : rand_coord(),
                        rand_coord(), rand_coord(), rand_coord() & 32'h7FFF_FFFF);
            no_idle = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 50; k++)
                send_point(rand_coord(), rand_coord(), rand_coord());
            no_idle = 1'b0;
        end
    endtask

    // Result side: random ready, compare against the oldest expectation.
    // Ready stays high between back-to-back items; it drops only before a wait.
    initial
    begin : result_check
        dist_item_t exp_item;
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 15);
            if (stall != 0)
            begin
                result.ready <= 1'b0;
                repeat (stall)
                    @(posedge clk);
            end
            result.ready <= 1'b1;
            @(posedge clk);
            while (!result.valid)
                @(posedge clk);
            if (expected_dist_q.size() == 0)
                report_mismatch("result item with nothing expected");
            else
            begin
                exp_item = expected_dist_q.pop_front();
                if (result.dist_res !== exp_item.dist_val)
                    report_mismatch($sformatf("dist_res %h, expected %h",
                                              result.dist_res, exp_item.dist_val));
                if (result.saturated !== exp_item.sat)
                    report_mismatch($sformatf("saturated %b, expected %b",
                                              result.saturated, exp_item.sat));
            end
        end
    end

    // Watchdog on a cycle counter.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > psd_tb_pkg::CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        seg_org[0] = 0;
        seg_org[1] = 0;
        seg_org[2] = 0;
        seg_dir[0] = 64'sd65536;
        seg_dir[1] = 0;
        seg_dir[2] = 0;
        seg_max = 0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        // Wait after reset; the direction sequencer stays idle with the reset unit direction.
        repeat (200)
            @(posedge clk);
        test_reset_segment();
        test_directed();
        test_random();
        drain_block();
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
